FILE: rtl/core/u8sv_pkg.sv
// ----------------------------------------------------------------------------
// u8sv_pkg
// Shared types and constants of the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package u8sv_pkg;

  // Default byte limit of one buffer.
  localparam longint unsigned MAX_BYTES_DEF   = 64'd65535;
  // Default depth of the internal queues.
  localparam int unsigned     QUEUE_DEPTH_DEF = 2;

  // Byte class boundaries.
  localparam logic [7:0] ASCII_MAX = 8'h7f;
  localparam logic [7:0] LEAD2_MIN = 8'hc2;
  localparam logic [7:0] LEAD2_MAX = 8'hdf;
  localparam logic [7:0] LEAD3_MIN = 8'he0;
  localparam logic [7:0] LEAD3_MAX = 8'hef;
  localparam logic [7:0] LEAD4_MIN = 8'hf0;
  localparam logic [7:0] LEAD4_MAX = 8'hf4;
  localparam logic [7:0] CONT_MASK = 8'hc0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // Code point limits.
  localparam logic [20:0] CP_MIN3     = 21'h000800;
  localparam logic [20:0] CP_MIN4     = 21'h010000;
  localparam logic [20:0] CP_MAX      = 21'h10ffff;
  localparam logic [20:0] SURR_LO     = 21'h00d800;
  localparam logic [20:0] SURR_HI     = 21'h00dfff;

  typedef enum logic [2:0] {
    BC_ASCII,
    BC_LEAD2,
    BC_LEAD3,
    BC_LEAD4,
    BC_CONT,
    BC_BAD
  } byte_class_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  // Classified beat handed from front to back.
  typedef struct packed {
    byte_class_t cls;
    logic [5:0]  bits;
    logic        has_byte;
    logic        last;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] valid_len;
  } result_t;

endpackage

FILE: rtl/core/u8sv_fifo.sv
// ----------------------------------------------------------------------------
// u8sv_fifo
// Small register queue used between the validator stages.
// ----------------------------------------------------------------------------
module u8sv_fifo #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = u8sv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/u8sv_front.sv
// ----------------------------------------------------------------------------
// u8sv_front
// Accepts input beats and classifies each byte for the back end.
// ----------------------------------------------------------------------------
module u8sv_front (
  input  logic            push,
  input  logic [7:0]      data_byte,
  input  logic            has_byte,
  input  logic            last,
  input  logic            q_full,
  output logic            full,
  output logic            q_wr,
  output u8sv_pkg::item_t item
);

  u8sv_pkg::byte_class_t cls;

  always_comb begin
    priority if (data_byte <= u8sv_pkg::ASCII_MAX) begin
      cls = u8sv_pkg::BC_ASCII;
    end else if ((data_byte & u8sv_pkg::CONT_MASK) == u8sv_pkg::CONT_TAG) begin
      cls = u8sv_pkg::BC_CONT;
    end else if (data_byte >= u8sv_pkg::LEAD2_MIN && data_byte <= u8sv_pkg::LEAD2_MAX) begin
      cls = u8sv_pkg::BC_LEAD2;
    end else if (data_byte >= u8sv_pkg::LEAD3_MIN && data_byte <= u8sv_pkg::LEAD3_MAX) begin
      cls = u8sv_pkg::BC_LEAD3;
    end else if (data_byte >= u8sv_pkg::LEAD4_MIN && data_byte <= u8sv_pkg::LEAD4_MAX) begin
      cls = u8sv_pkg::BC_LEAD4;
    end else begin
      cls = u8sv_pkg::BC_BAD;
    end
  end

  assign full          = q_full;
  assign q_wr          = push && !q_full;
  assign item.cls      = cls;
  assign item.bits     = data_byte[5:0];
  assign item.has_byte = has_byte;
  assign item.last     = last;

endmodule

FILE: rtl/core/u8sv_back.sv
// ----------------------------------------------------------------------------
// u8sv_back
// Runs the per-buffer decode state and builds the result on the last beat.
// ----------------------------------------------------------------------------
module u8sv_back #(
  parameter longint unsigned MAX_BYTES = u8sv_pkg::MAX_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              trunc_ok,
  input  u8sv_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_take,
  input  logic              res_full,
  output logic              res_wr,
  output u8sv_pkg::result_t res
);

  localparam int unsigned CNT_W = $clog2(MAX_BYTES + 64'd2);

  logic [CNT_W-1:0] count_r,    count_upd;
  logic [15:0]      boundary_r, boundary_upd;
  logic [1:0]       remain_r,   remain_upd;
  logic [2:0]       size_r,     size_upd;
  logic [20:0]      acc_r,      acc_upd;
  logic             seq_bad_r,  seq_bad_upd;
  logic             sticky_r,   sticky_upd;
  logic             step;

  assign item_take = item_valid && !res_full;
  assign step      = item_take;
  assign res_wr    = step && item.last;

  always_comb begin
    count_upd    = count_r;
    boundary_upd = boundary_r;
    remain_upd   = remain_r;
    size_upd     = size_r;
    acc_upd      = acc_r;
    seq_bad_upd  = seq_bad_r;
    sticky_upd   = sticky_r;
    if (item.has_byte) begin
      if (remain_r == 2'd0) begin
        boundary_upd = 16'(count_r);
        seq_bad_upd  = 1'b0;
        unique case (item.cls)
          u8sv_pkg::BC_ASCII: begin
            size_upd = 3'd1;
          end
          u8sv_pkg::BC_LEAD2: begin
            size_upd   = 3'd2;
            remain_upd = 2'd1;
            acc_upd    = {16'd0, item.bits[4:0]};
          end
          u8sv_pkg::BC_LEAD3: begin
            size_upd   = 3'd3;
            remain_upd = 2'd2;
            acc_upd    = {17'd0, item.bits[3:0]};
          end
          u8sv_pkg::BC_LEAD4: begin
            size_upd   = 3'd4;
            remain_upd = 2'd3;
            acc_upd    = {18'd0, item.bits[2:0]};
          end
          default: begin
            sticky_upd = 1'b1;
          end
        endcase
      end else begin
        // any byte inside a sequence takes a continuation slot; a non-continuation byte marks it bad
        if (item.cls != u8sv_pkg::BC_CONT) begin
          seq_bad_upd = 1'b1;
        end
        acc_upd    = {acc_r[14:0], item.bits};
        remain_upd = remain_r - 2'd1;
        if (remain_upd == 2'd0) begin
          if (seq_bad_upd
              || (size_r == 3'd3 && acc_upd < u8sv_pkg::CP_MIN3)
              || (size_r == 3'd4 && acc_upd < u8sv_pkg::CP_MIN4)
              || acc_upd > u8sv_pkg::CP_MAX
              || (acc_upd >= u8sv_pkg::SURR_LO && acc_upd <= u8sv_pkg::SURR_HI)) begin
            sticky_upd = 1'b1;
          end
          seq_bad_upd = 1'b0;
        end
      end
      if (count_r <= CNT_W'(MAX_BYTES)) begin
        count_upd = count_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    res.valid_len = 16'd0;
    priority if (count_upd > CNT_W'(MAX_BYTES)) begin
      res.status = u8sv_pkg::ST_TOO_LONG;
    end else if (sticky_upd) begin
      res.status = u8sv_pkg::ST_INVALID;
    end else if (remain_upd != 2'd0) begin
      if (trunc_ok) begin
        res.status    = u8sv_pkg::ST_OK;
        res.valid_len = boundary_upd;
      end else begin
        res.status = u8sv_pkg::ST_INVALID;
      end
    end else begin
      res.status    = u8sv_pkg::ST_OK;
      res.valid_len = 16'(count_upd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      boundary_r <= '0;
      remain_r   <= '0;
      size_r     <= '0;
      acc_r      <= '0;
      seq_bad_r  <= 1'b0;
      sticky_r   <= 1'b0;
    end else if (step) begin
      if (item.last) begin
        count_r    <= '0;
        boundary_r <= '0;
        remain_r   <= '0;
        size_r     <= '0;
        acc_r      <= '0;
        seq_bad_r  <= 1'b0;
        sticky_r   <= 1'b0;
      end else begin
        count_r    <= count_upd;
        boundary_r <= boundary_upd;
        remain_r   <= remain_upd;
        size_r     <= size_upd;
        acc_r      <= acc_upd;
        seq_bad_r  <= seq_bad_upd;
        sticky_r   <= sticky_upd;
      end
    end
  end

endmodule

FILE: rtl/core/utf8_stream_validator_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator_unit
// Strict UTF-8 checker for a byte stream, one status beat per buffer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | in        | in_push / in_full    | in_data_byte, in_has_byte, in_last
//  out_    | out       | out_empty / out_pop  | out_status, out_valid_len
//  cfg_    | in        | cfg_valid/cfg_ready  | cfg_trunc_ok
//
//  One byte beat per cycle sustained while out_ is not stalled. The front
//  classifies and queues a byte; the back end consumes one queued beat per cycle
//  unless the result queue is full and, on a last beat, queues the result.
//  Reset is synchronous, active low; it empties both queues and clears the
//  per-buffer state and trunc_ok. A stalled out_ side fills the result
//  queue, then the beat queue, then raises in_full.
// ----------------------------------------------------------------------------
module utf8_stream_validator_unit #(
  parameter longint unsigned MAX_BYTES   = u8sv_pkg::MAX_BYTES_DEF,
  parameter int unsigned     QUEUE_DEPTH = u8sv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  // result output
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_status,
  output logic [15:0] out_valid_len,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_trunc_ok
);

  localparam int unsigned ITEM_W = $bits(u8sv_pkg::item_t);
  localparam int unsigned RES_W  = $bits(u8sv_pkg::result_t);

  logic trunc_ok_r;

  // front -> beat queue
  u8sv_pkg::item_t   front_item;
  logic              front_wr;
  logic              mid_full;
  logic [ITEM_W-1:0] mid_rdata;
  logic              mid_empty;
  u8sv_pkg::item_t   back_item;
  logic              back_take;

  // back -> result queue
  u8sv_pkg::result_t back_res;
  logic              res_wr;
  logic              res_full;
  logic [RES_W-1:0]  res_rdata;
  u8sv_pkg::result_t out_res;

  // register write accepted any time; the user must write it only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trunc_ok_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      trunc_ok_r <= cfg_trunc_ok;
    end
  end

  u8sv_front u_front (
    .push      (in_push),
    .data_byte (in_data_byte),
    .has_byte  (in_has_byte),
    .last      (in_last),
    .q_full    (mid_full),
    .full      (in_full),
    .q_wr      (front_wr),
    .item      (front_item)
  );

  u8sv_fifo #(
    .W     (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_wr),
    .wr_data (front_item),
    .full    (mid_full),
    .rd_en   (back_take),
    .rd_data (mid_rdata),
    .empty   (mid_empty)
  );

  assign back_item = u8sv_pkg::item_t'(mid_rdata);

  u8sv_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .trunc_ok   (trunc_ok_r),
    .item       (back_item),
    .item_valid (!mid_empty),
    .item_take  (back_take),
    .res_full   (res_full),
    .res_wr     (res_wr),
    .res        (back_res)
  );

  u8sv_fifo #(
    .W     (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (back_res),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (res_rdata),
    .empty   (out_empty)
  );

  assign out_res       = u8sv_pkg::result_t'(res_rdata);
  assign out_status    = out_res.status;
  assign out_valid_len = out_res.valid_len;

endmodule
